@@ design/salc_pkg.sv @@
// shared types, constants and command struct of the set-associative lru tag tracker
// no dependencies
package salc_pkg;

  localparam int MAX_SET_BITS = 8;
  localparam int WAYS         = 8;
  localparam int ADDR_WIDTH   = 64;
  localparam int STAMP_WIDTH  = 32;
  localparam int COUNT_WIDTH  = 32;
  localparam int CFG_WIDTH    = 4;

  localparam int NSETS   = 1 << MAX_SET_BITS;
  localparam int SET_W   = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
  localparam int WAY_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int TREE_N  = 1 << WAY_W;
  localparam int NWAY_W  = $clog2(WAYS + 1) + 1;
  localparam int SHIFT_W = 5;

  // access kinds
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
  localparam logic [1:0] CFG_WAYS        = 2'd2;

  // one memory row holds a whole set and its clock
  typedef struct packed {
    logic [WAYS-1:0]                  valid;
    logic [WAYS-1:0][ADDR_WIDTH-1:0]  tag;
    logic [WAYS-1:0][STAMP_WIDTH-1:0] stamp;
    logic [STAMP_WIDTH-1:0]           clock;
  } row_t;

  typedef struct packed {
    logic             latch;
    logic             lookup;
    logic             update;
    logic             clear;
    logic [SET_W-1:0] clear_set;
  } cmd_t;

endpackage

@@ design/salc_ctrl.sv @@
// sequencer of the lru tag tracker: clearing pass, lookup and update steps
// depends on salc_pkg
module salc_ctrl import salc_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output cmd_t cmd
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_LOOKUP = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0]       state;
  logic [1:0]       state_next;
  logic [SET_W-1:0] clear_cnt;
  logic             accept;

  // the update step overlaps the transfer of the next access
  assign busy   = (state == ST_CLEAR) || (state == ST_LOOKUP);
  assign accept = start && !busy;

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clear_cnt == SET_W'(NSETS - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) state_next = ST_LOOKUP;
      end
      ST_LOOKUP: state_next = ST_UPDATE;
      ST_UPDATE: begin
        state_next = accept ? ST_LOOKUP : ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clear_cnt <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clear_cnt <= clear_cnt + 1'b1;
    end
  end

  always_comb begin
    cmd.latch     = accept;
    cmd.lookup    = (state == ST_LOOKUP);
    cmd.update    = (state == ST_UPDATE);
    cmd.clear     = (state == ST_CLEAR);
    cmd.clear_set = clear_cnt;
  end

endmodule

@@ design/salc_datapath.sv @@
// datapath of the lru tag tracker: config registers, address split, set memory,
// way match and victim select, counters and result registers
// depends on salc_pkg
module salc_datapath import salc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  input  logic [1:0]             op,
  input  logic [ADDR_WIDTH-1:0]  address,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  output logic                   done,
  output logic                   was_hit,
  output logic                   was_evicted,
  output logic                   second_hit,
  output logic [COUNT_WIDTH-1:0] total_hits,
  output logic [COUNT_WIDTH-1:0] total_misses,
  output logic [COUNT_WIDTH-1:0] total_evictions
);

  logic [CFG_WIDTH-1:0]   set_bits;
  logic [CFG_WIDTH-1:0]   offset_bits;
  logic [CFG_WIDTH-1:0]   ways_cfg;

  logic [1:0]             op_r;
  logic [ADDR_WIDTH-1:0]  addr_r;
  logic [ADDR_WIDTH-1:0]  tag_r;
  logic [SET_W-1:0]       set_r;
  logic                   modify_r;

  row_t                   ram [NSETS];
  row_t                   row_rd;
  row_t                   row_wr;

  logic [CFG_WIDTH-1:0]   s_eff;
  logic [SHIFT_W-1:0]     tag_shift;
  logic [ADDR_WIDTH-1:0]  shifted;
  logic [SET_W-1:0]       set_mask;
  logic [SET_W-1:0]       set_calc;
  logic [ADDR_WIDTH-1:0]  tag_calc;

  logic [NWAY_W-1:0]      nways_eff;
  logic [WAYS-1:0]        active;
  logic [WAYS-1:0]        match;
  logic [WAYS-1:0]        free;
  logic                   hit;
  logic                   any_free;
  logic                   evict;
  logic [WAY_W-1:0]       hit_way;
  logic [WAY_W-1:0]       free_way;
  logic [WAY_W-1:0]       lru_way;
  logic [WAY_W-1:0]       victim;
  logic [STAMP_WIDTH-1:0] new_clock;

  logic [TREE_N-1:0]                  t_act;
  logic [TREE_N-1:0][STAMP_WIDTH-1:0] t_val;
  logic [TREE_N-1:0][WAY_W-1:0]       t_idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= CFG_WIDTH'(4);
      offset_bits <= CFG_WIDTH'(4);
      ways_cfg    <= CFG_WIDTH'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_SET_BITS:    set_bits    <= cfg_data;
        CFG_OFFSET_BITS: offset_bits <= cfg_data;
        CFG_WAYS:        ways_cfg    <= cfg_data;
        default: ;
      endcase
    end
  end

  // address split, used in the lookup step
  always_comb begin
    s_eff     = (set_bits > CFG_WIDTH'(MAX_SET_BITS)) ? CFG_WIDTH'(MAX_SET_BITS) : set_bits;
    tag_shift = SHIFT_W'(offset_bits) + SHIFT_W'(s_eff);
    shifted   = addr_r >> offset_bits;
    set_mask  = ~({SET_W{1'b1}} << s_eff);
    set_calc  = shifted[SET_W-1:0] & set_mask;
    tag_calc  = addr_r >> tag_shift;
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= op;
      addr_r <= address;
    end
    if (cmd.lookup) begin
      set_r    <= set_calc;
      tag_r    <= tag_calc;
      modify_r <= (op_r == OP_MODIFY);
      row_rd   <= ram[set_calc];
    end
    if (cmd.clear) begin
      ram[cmd.clear_set] <= '0;
    end else if (cmd.update) begin
      ram[set_r] <= row_wr;
    end
  end

  // way match and first free way over the ways in use
  always_comb begin
    if (ways_cfg == '0) begin
      nways_eff = NWAY_W'(1);
    end else if (NWAY_W'(ways_cfg) > NWAY_W'(WAYS)) begin
      nways_eff = NWAY_W'(WAYS);
    end else begin
      nways_eff = NWAY_W'(ways_cfg);
    end
    hit_way  = '0;
    free_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      active[w] = NWAY_W'(w) < nways_eff;
      match[w]  = active[w] && row_rd.valid[w] && (row_rd.tag[w] == tag_r);
      free[w]   = active[w] && !row_rd.valid[w];
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (match[w]) hit_way = WAY_W'(w);
      if (free[w])  free_way = WAY_W'(w);
    end
    hit      = |match;
    any_free = |free;
    evict    = !hit && !any_free;
  end

  // lowest stamp by pairwise tree, the left (lower) way keeps ties
  always_comb begin
    for (int i = 0; i < TREE_N; i++) begin
      if (i < WAYS) begin
        t_act[i] = active[i];
        t_val[i] = row_rd.stamp[i];
      end else begin
        t_act[i] = 1'b0;
        t_val[i] = '0;
      end
      t_idx[i] = WAY_W'(i);
    end
    for (int lvl = 0; lvl < WAY_W; lvl++) begin
      for (int i = 0; i < TREE_N; i += (2 << lvl)) begin
        if (t_act[i + (1 << lvl)] &&
            (!t_act[i] || (t_val[i + (1 << lvl)] < t_val[i]))) begin
          t_act[i] = t_act[i + (1 << lvl)];
          t_val[i] = t_val[i + (1 << lvl)];
          t_idx[i] = t_idx[i + (1 << lvl)];
        end
      end
    end
    lru_way = t_idx[0];
  end

  // a modify ticks the set clock twice and always hits the second time
  always_comb begin
    victim    = hit ? hit_way : (any_free ? free_way : lru_way);
    new_clock = row_rd.clock + (modify_r ? STAMP_WIDTH'(2) : STAMP_WIDTH'(1));
    row_wr                = row_rd;
    row_wr.valid[victim]  = 1'b1;
    row_wr.tag[victim]    = tag_r;
    row_wr.stamp[victim]  = new_clock;
    row_wr.clock          = new_clock;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done            <= 1'b0;
      total_hits      <= '0;
      total_misses    <= '0;
      total_evictions <= '0;
    end else begin
      done <= cmd.update;
      if (cmd.update) begin
        total_hits      <= total_hits + COUNT_WIDTH'(hit) + COUNT_WIDTH'(modify_r);
        total_misses    <= total_misses + COUNT_WIDTH'(!hit);
        total_evictions <= total_evictions + COUNT_WIDTH'(evict);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      was_hit     <= hit;
      was_evicted <= evict;
      second_hit  <= modify_r;
    end
  end

endmodule

@@ design/set_assoc_lru_cache_tracker_core.sv @@
// top level of the set-associative lru tag tracker
// depends on salc_pkg, salc_ctrl and salc_datapath
//
// Tracks the tags of a cache of up to 256 sets and 8 ways with lru replacement. After reset, busy
// stays high for a clearing pass, one set row per cycle. An access is transferred at a clock edge
// with start high and busy low; it reads its set row from the single-port set memory in a lookup
// step, then updates and writes the row back in an update step, and a new access may be
// transferred during the update step. The result is shown for exactly one cycle with done high,
// in the cycle after the update; the receiver cannot hold it off. Configuration writes are taken
// at any edge with cfg_write high and must only be issued while no access is in flight.
module set_assoc_lru_cache_tracker_core import salc_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             op,
  input  logic [ADDR_WIDTH-1:0]  address,
  input  logic                   cfg_write,
  input  logic [1:0]             cfg_index,
  input  logic [CFG_WIDTH-1:0]   cfg_data,
  output logic                   done,
  output logic                   was_hit,
  output logic                   was_evicted,
  output logic                   second_hit,
  output logic [COUNT_WIDTH-1:0] total_hits,
  output logic [COUNT_WIDTH-1:0] total_misses,
  output logic [COUNT_WIDTH-1:0] total_evictions
);

  cmd_t cmd;

  salc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  salc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .op              (op),
    .address         (address),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .was_hit         (was_hit),
    .was_evicted     (was_evicted),
    .second_hit      (second_hit),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions)
  );

  // a transfer always moves on to the lookup step
  a_accept_lookup: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> cmd.lookup)
    else $error("transfer not followed by lookup");

  // a result only follows an update step
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.update))
    else $error("result without update");

  // every access bumps the hit or the miss count
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (done && !$past(rst)) |->
      ((total_hits != $past(total_hits)) || (total_misses != $past(total_misses))))
    else $error("counters did not move");

  // a hit never evicts
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    done |-> !(was_hit && was_evicted))
    else $error("eviction reported on a hit");

endmodule

@@ test/tb.sv @@
// self-checking testbench for set_assoc_lru_cache_tracker_core: a queued driver feeds accesses
// and register writes, a monitor predicts each lru lookup and compares the strobed result
// depends on salc_pkg and the design files under design/
`timescale 1ns / 100ps

module tb;
  import salc_pkg::*;

  // codes outside the package lists
  localparam logic [1:0] OP_UNKNOWN = 2'd3;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  typedef enum logic [1:0] {ACT_ACCESS, ACT_CONFIG, ACT_DRAIN} action_t;

  typedef struct {
    action_t               act;
    logic [1:0]            op;
    logic [ADDR_WIDTH-1:0] address;
    logic [1:0]            reg_sel;
    logic [CFG_WIDTH-1:0]  reg_val;
    int                    gap;
  } plan_step_t;

  typedef struct packed {
    logic                   was_hit;
    logic                   was_evicted;
    logic                   second_hit;
    logic [COUNT_WIDTH-1:0] hits;
    logic [COUNT_WIDTH-1:0] misses;
    logic [COUNT_WIDTH-1:0] evictions;
  } lookup_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   start = 1'b0;
  logic [1:0]             op = OP_LOAD;
  logic [ADDR_WIDTH-1:0]  address = '0;
  logic                   cfg_write = 1'b0;
  logic [1:0]             cfg_index = CFG_SET_BITS;
  logic [CFG_WIDTH-1:0]   cfg_data = '0;
  logic                   busy;
  logic                   done;
  logic                   was_hit;
  logic                   was_evicted;
  logic                   second_hit;
  logic [COUNT_WIDTH-1:0] total_hits;
  logic [COUNT_WIDTH-1:0] total_misses;
  logic [COUNT_WIDTH-1:0] total_evictions;

  set_assoc_lru_cache_tracker_core u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .op              (op),
    .address         (address),
    .cfg_write       (cfg_write),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .done            (done),
    .was_hit         (was_hit),
    .was_evicted     (was_evicted),
    .second_hit      (second_hit),
    .total_hits      (total_hits),
    .total_misses    (total_misses),
    .total_evictions (total_evictions)
  );

  always #4 clk = ~clk;

  // shadow tag store
  logic                   line_ok   [NSETS][WAYS];
  logic [ADDR_WIDTH-1:0]  line_tag  [NSETS][WAYS];
  logic [STAMP_WIDTH-1:0] line_age  [NSETS][WAYS];
  logic [STAMP_WIDTH-1:0] set_clock [NSETS];
  logic [COUNT_WIDTH-1:0] hit_total, miss_total, evict_total;
  logic [CFG_WIDTH-1:0]   set_bits_reg, offset_bits_reg, ways_reg;

  plan_step_t     access_plan[$];
  lookup_result_t pending_lookups[$];

  int  mismatches = 0;
  int  lookups_checked = 0;
  int  kind_tally[4] = '{0, 0, 0, 0};
  int  geometries = 1;
  logic taken = 1'b0;
  int  gap_left = 0;
  bit  gap_loaded = 1'b0;
  int  quiet = 0;

  // generator's view of the register settings, already clamped
  int gen_s = 4;
  int gen_b = 4;
  int gen_w = 1;

  // one access to one set; updates the shadow store and counters
  task automatic probe_set(input int set_idx, input logic [ADDR_WIDTH-1:0] tag,
                           input int nways, output logic hit, output logic evicted);
    int victim;
    bit have_free;
    hit = 1'b0;
    evicted = 1'b0;
    have_free = 1'b0;
    victim = 0;
    for (int w = 0; w < nways; w++)
      if (!hit && line_ok[set_idx][w] && line_tag[set_idx][w] == tag) begin
        set_clock[set_idx] = set_clock[set_idx] + 1'b1;
        line_age[set_idx][w] = set_clock[set_idx];
        hit = 1'b1;
      end
    if (hit) begin
      hit_total = hit_total + 1'b1;
      return;
    end
    miss_total = miss_total + 1'b1;
    for (int w = 0; w < nways; w++)
      if (!have_free && !line_ok[set_idx][w]) begin
        victim = w;
        have_free = 1'b1;
      end
    if (!have_free) begin
      // oldest stamp goes, lowest way on a tie
      for (int w = 1; w < nways; w++)
        if (line_age[set_idx][w] < line_age[set_idx][victim]) victim = w;
      evict_total = evict_total + 1'b1;
      evicted = 1'b1;
    end
    line_ok[set_idx][victim] = 1'b1;
    line_tag[set_idx][victim] = tag;
    set_clock[set_idx] = set_clock[set_idx] + 1'b1;
    line_age[set_idx][victim] = set_clock[set_idx];
  endtask

  task automatic track_access(input logic [1:0] kind, input logic [ADDR_WIDTH-1:0] addr);
    int s, b, nways, set_idx;
    logic [ADDR_WIDTH-1:0] tag;
    logic h1, e1, h2, e2;
    lookup_result_t r;
    s = (set_bits_reg > MAX_SET_BITS) ? MAX_SET_BITS : int'(set_bits_reg);
    b = int'(offset_bits_reg);
    nways = int'(ways_reg);
    if (nways < 1) nways = 1;
    if (nways > WAYS) nways = WAYS;
    set_idx = int'((addr >> b) & ((64'd1 << s) - 64'd1));
    tag = addr >> (b + s);
    h2 = 1'b0;
    probe_set(set_idx, tag, nways, h1, e1);
    if (kind == OP_MODIFY) probe_set(set_idx, tag, nways, h2, e2);
    r.was_hit = h1;
    r.was_evicted = e1;
    r.second_hit = h2;
    r.hits = hit_total;
    r.misses = miss_total;
    r.evictions = evict_total;
    pending_lookups.push_back(r);
    kind_tally[kind]++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // monitor: predicts on every accepted transfer, checks every strobed result
  always @(posedge clk) begin : watch_results
    lookup_result_t want;
    taken <= !rst && start && !busy;
    if (rst) begin
      for (int i = 0; i < NSETS; i++) begin
        set_clock[i] = '0;
        for (int w = 0; w < WAYS; w++) begin
          line_ok[i][w] = 1'b0;
          line_tag[i][w] = '0;
          line_age[i][w] = '0;
        end
      end
      hit_total = '0;
      miss_total = '0;
      evict_total = '0;
      set_bits_reg = 4'd4;
      offset_bits_reg = 4'd4;
      ways_reg = 4'd1;
    end else begin
      if (done) begin
        if (pending_lookups.size() == 0) begin
          mismatches++;
          $display("%0t: result with no access pending, expected none, got hit %0b evict %0b",
                   $time, was_hit, was_evicted);
        end else begin
          want = pending_lookups.pop_front();
          check_field("was_hit", want.was_hit, was_hit);
          check_field("was_evicted", want.was_evicted, was_evicted);
          check_field("second_hit", want.second_hit, second_hit);
          check_field("total_hits", want.hits, total_hits);
          check_field("total_misses", want.misses, total_misses);
          check_field("total_evictions", want.evictions, total_evictions);
          lookups_checked++;
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_reg = cfg_data;
          CFG_OFFSET_BITS: offset_bits_reg = cfg_data;
          CFG_WAYS:        ways_reg = cfg_data;
          default: ;
        endcase
      end
      if (start && !busy) track_access(op, address);
    end
  end

  // driver: holds start until the transfer, register writes only once everything has drained
  always @(negedge clk) begin : drive_items
    logic hold, pulse;
    plan_step_t head;
    hold = start && !taken;
    pulse = 1'b0;
    if (!rst && !busy && !start && pending_lookups.size() == 0) quiet++;
    else quiet = 0;
    if (!rst && !hold && access_plan.size() != 0) begin
      head = access_plan[0];
      case (head.act)
        ACT_ACCESS: begin
          if (!gap_loaded) begin
            gap_left = head.gap;
            gap_loaded = 1'b1;
          end
          if (gap_left > 0) gap_left--;
          else begin
            hold = 1'b1;
            op <= head.op;
            address <= head.address;
            gap_loaded = 1'b0;
            access_plan.delete(0);
          end
        end
        ACT_CONFIG: if (quiet >= 3) begin
          pulse = 1'b1;
          cfg_index <= head.reg_sel;
          cfg_data <= head.reg_val;
          quiet = 0;
          access_plan.delete(0);
        end
        default: if (quiet >= 3) begin
          quiet = 0;
          access_plan.delete(0);
        end
      endcase
    end
    start <= hold;
    cfg_write <= pulse;
  end

  task automatic add_access(input logic [1:0] kind, input logic [ADDR_WIDTH-1:0] addr,
                            input int gap);
    plan_step_t p;
    p.act = ACT_ACCESS;
    p.op = kind;
    p.address = addr;
    p.reg_sel = CFG_SET_BITS;
    p.reg_val = '0;
    p.gap = gap;
    access_plan.push_back(p);
  endtask

  task automatic add_drain();
    plan_step_t p;
    p.act = ACT_DRAIN;
    p.op = OP_LOAD;
    p.address = '0;
    p.reg_sel = CFG_SET_BITS;
    p.reg_val = '0;
    p.gap = 0;
    access_plan.push_back(p);
  endtask

  task automatic add_config(input logic [1:0] idx, input logic [CFG_WIDTH-1:0] val);
    plan_step_t p;
    p.act = ACT_CONFIG;
    p.op = OP_LOAD;
    p.address = '0;
    p.reg_sel = idx;
    p.reg_val = val;
    p.gap = 0;
    access_plan.push_back(p);
    case (idx)
      CFG_SET_BITS:    gen_s = (val > MAX_SET_BITS) ? MAX_SET_BITS : int'(val);
      CFG_OFFSET_BITS: gen_b = int'(val);
      CFG_WAYS:        gen_w = (val == 0) ? 1 : (val > WAYS) ? WAYS : int'(val);
      default: ;
    endcase
  endtask

  task automatic set_geometry(input int s, input int b, input int w);
    add_config(CFG_SET_BITS, CFG_WIDTH'(s));
    add_config(CFG_OFFSET_BITS, CFG_WIDTH'(b));
    add_config(CFG_WAYS, CFG_WIDTH'(w));
    geometries++;
  endtask

  function automatic logic [ADDR_WIDTH-1:0] compose_address(input int set_idx,
      input logic [ADDR_WIDTH-1:0] tag, input logic [ADDR_WIDTH-1:0] offset);
    logic [ADDR_WIDTH-1:0] set_mask, off_mask;
    set_mask = (64'd1 << gen_s) - 64'd1;
    off_mask = (64'd1 << gen_b) - 64'd1;
    return (tag << (gen_b + gen_s)) | ((64'(set_idx) & set_mask) << gen_b) | (offset & off_mask);
  endfunction

  // mostly a few hot sets and a small tag pool so hits and evictions keep coming
  task automatic random_phase(input int count);
    logic [ADDR_WIDTH-1:0] tag_pool[12];
    logic [ADDR_WIDTH-1:0] addr;
    int set_span, burst, gap, set_idx;
    set_span = ((1 << gen_s) < 4) ? (1 << gen_s) : 4;
    for (int k = 0; k < 12; k++)
      tag_pool[k] = (k < 6) ? 64'(k) : {$urandom, $urandom};
    burst = 0;
    for (int k = 0; k < count; k++) begin
      if (k % 32 == 0) burst = ($urandom_range(0, 2) == 0);
      gap = burst ? 0 : $urandom_range(0, 6);
      if ($urandom_range(0, 9) < 8) begin
        set_idx = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (1 << gen_s) - 1)
                                              : $urandom_range(0, set_span - 1);
        addr = compose_address(set_idx, tag_pool[$urandom_range(0, gen_w + 3)],
                               {$urandom, $urandom});
      end else begin
        addr = {$urandom, $urandom};
      end
      add_access(2'($urandom_range(OP_LOAD, OP_UNKNOWN)), addr, gap);
      if (k == count / 2 && $urandom_range(0, 1) == 1) add_drain();
    end
  endtask

  initial begin : run_test
    int phase_s[7] = '{0, 8, 15, 3, 1, 8, 5};
    int phase_b[7] = '{0, 12, 15, 6, 3, 0, 15};
    int phase_w[7] = '{8, 4, 15, 0, 2, 8, 3};
    int k;

    // reset geometry: 16 sets, 16-byte blocks, one way
    add_access(OP_LOAD, 64'h0, 0);
    add_access(OP_LOAD, 64'h0, 0);
    add_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 3);
    add_access(OP_MODIFY, 64'h10, 0);
    add_access(OP_UNKNOWN, 64'h100, 6);
    add_access(OP_LOAD, 64'h0, 1);
    // sender holds off until every result is back
    add_drain();

    set_geometry(2, 0, 8);
    add_config(CFG_UNUSED, 4'hF);
    for (int t = 1; t < 8; t++) add_access(OP_LOAD, compose_address(0, 64'(t), 0), 0);
    add_access(OP_STORE, compose_address(0, 64'd8, 0), 2);
    add_access(OP_LOAD, compose_address(0, 64'd1, 0), 0);
    add_access(OP_MODIFY, compose_address(0, 64'd10, 0), 0);
    add_access(OP_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 5);

    for (int ph = 0; ph < 7; ph++) begin
      set_geometry(phase_s[ph], phase_b[ph], phase_w[ph]);
      random_phase(153);
    end
    for (int ph = 0; ph < 3; ph++) begin
      set_geometry($urandom_range(0, 15), $urandom_range(0, 15), $urandom_range(0, 15));
      random_phase(153);
    end

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (access_plan.size() != 0 || start) @(posedge clk);
    for (k = 0; k < 200 && pending_lookups.size() != 0; k++) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      mismatches += pending_lookups.size();
      $display("%0t: %0d accesses expected a result, got none", $time, pending_lookups.size());
    end
    repeat (8) @(posedge clk);

    $display("checked %0d lookups over %0d cache geometries: %0d hits, %0d misses, %0d evictions",
             lookups_checked, geometries, hit_total, miss_total, evict_total);
    $display("access mix: %0d load, %0d store, %0d modify, %0d unknown kind",
             kind_tally[0], kind_tally[1], kind_tally[2], kind_tally[3]);
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
